### rtl/bilinear_table_interpolator_core_macros.svh
// Assertion macros for the bilinear table interpolator.
// Used by the files that assert; needs clk and rst_n in scope.
`ifndef BILINEAR_TABLE_INTERPOLATOR_CORE_MACROS_SVH
`define BILINEAR_TABLE_INTERPOLATOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define BTI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BTI_NEVER(lbl, expr, msg) \
    `BTI_ASSERT(lbl, !(expr), msg)
`else
`define BTI_ASSERT(lbl, prop, msg)
`define BTI_NEVER(lbl, expr, msg)
`endif
`endif

### rtl/bti_pkg.sv
// Shared types and constants of the bilinear table interpolator.
// No dependencies.
`timescale 1ns / 1ps
package bti_pkg;

    localparam int MAX_ROWS_DEF = 8;
    localparam int MAX_COLS_DEF = 8;
    localparam int DATA_W       = 32;
    localparam int FRAC_W       = 16;
    localparam logic [FRAC_W:0] FRAC_ONE = 17'h10000;
    localparam int DIV_STEPS    = FRAC_W;
    localparam int LOC_LAT      = 3;
    localparam int DIV_LAT      = DIV_STEPS + 2;
    localparam int BLEND_LAT    = 3;

    // register indexes
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    typedef enum logic [1:0] {
        ACT_WR_X   = 2'd0,
        ACT_WR_Y   = 2'd1,
        ACT_WR_VAL = 2'd2,
        ACT_QUERY  = 2'd3
    } action_t;

    typedef struct packed {
        logic clamp_lo;
        logic clamp_hi;
    } frac_ctl_t;

endpackage

### rtl/bilinear_table_interpolator_core.sv
// Top level of the bilinear table interpolator: storage, pipeline and APB registers.
// Depends on bti_pkg, bti_axis_locate, bti_frac_div, bti_blend and the macros header.
//
//  channel   | handshake               | payload
//  ----------+-------------------------+-------------------------------------------
//  item in   | start, busy             | action, row, col, data, query_x, query_y
//  result    | done (one-cycle strobe) | result, status
//  config    | psel, penable, pready   | paddr, pwrite, pwdata, prdata
//
// A query passes the axis search, the 16-stage fraction divider, the table read
// and the blends before done, and one query can be accepted every cycle.
// Write items are held off by busy while any query is still in the pipeline.
// Reset clears the size registers and all valid bits; table contents stay
// undefined until written. The receiver cannot stall: done is never held.
`timescale 1ns / 1ps
`include "bilinear_table_interpolator_core_macros.svh"
module bilinear_table_interpolator_core
    import bti_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int MAX_COLS = MAX_COLS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               action,
    input  logic [2:0]               row,
    input  logic [2:0]               col,
    input  logic signed [DATA_W-1:0] data,
    input  logic signed [DATA_W-1:0] query_x,
    input  logic signed [DATA_W-1:0] query_y,
    output logic                     done,
    output logic signed [DATA_W-1:0] result,
    output logic                     status,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [2:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam int XW  = $clog2(MAX_ROWS);
    localparam int YW  = $clog2(MAX_COLS);
    localparam int NXW = $clog2(MAX_ROWS + 1);
    localparam int NYW = $clog2(MAX_COLS + 1);
    localparam int HR  = (MAX_ROWS + 1) / 2;
    localparam int HC  = (MAX_COLS + 1) / 2;
    localparam int BANK_D  = HR * HC;
    localparam int BANK_AW = (BANK_D > 1) ? $clog2(BANK_D) : 1;
    localparam int LAT = 1 + LOC_LAT + DIV_LAT + 1 + 2 * BLEND_LAT + 1;
    localparam int CNTW = $clog2(LAT + 1);

    // configuration
    logic [3:0] rows_reg, cols_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= '0;
            cols_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_ROWS: rows_reg <= pwdata[3:0];
                REG_COLS: cols_reg <= pwdata[3:0];
                default:  rows_reg <= rows_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_ROWS: prdata = {28'd0, rows_reg};
            REG_COLS: prdata = {28'd0, cols_reg};
            default:  prdata = '0;
        endcase
    end

    // accept control
    logic            accept, q_accept, done_reg;
    logic [CNTW-1:0] inflight_reg, inflight_next;
    action_t         act;

    assign act      = action_t'(action);
    assign busy     = (inflight_reg != '0) && (act != ACT_QUERY);
    assign accept   = start && !busy;
    assign q_accept = accept && (act == ACT_QUERY);

    // count queries between acceptance and done
    always_comb
    begin
        inflight_next = inflight_reg + CNTW'(q_accept) - CNTW'(done_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= '0;
        else
            inflight_reg <= inflight_next;
    end

    // breakpoint storage
    logic signed [DATA_W-1:0] px_reg [MAX_ROWS];
    logic signed [DATA_W-1:0] py_reg [MAX_COLS];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_ROWS; i++)
        begin
            if (accept && act == ACT_WR_X && 32'(row) == i)
                px_reg[i] <= data;
        end
        for (int j = 0; j < MAX_COLS; j++)
        begin
            if (accept && act == ACT_WR_Y && 32'(col) == j)
                py_reg[j] <= data;
        end
    end

    // entry stage: saturate sizes, flag small tables
    logic                     e_vld_reg, e_inv_reg;
    logic signed [DATA_W-1:0] e_x_reg, e_y_reg;
    logic [NXW-1:0]           e_nx_reg, nx_sat;
    logic [NYW-1:0]           e_ny_reg, ny_sat;
    logic                     inv_next;

    always_comb
    begin
        nx_sat = (32'(rows_reg) > MAX_ROWS) ? NXW'(MAX_ROWS) : NXW'(rows_reg);
        ny_sat = (32'(cols_reg) > MAX_COLS) ? NYW'(MAX_COLS) : NYW'(cols_reg);
        inv_next = (nx_sat < NXW'(2)) || (ny_sat < NYW'(2));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_vld_reg <= 1'b0;
        else
            e_vld_reg <= q_accept;
    end

    always_ff @(posedge clk)
    begin
        e_x_reg   <= query_x;
        e_y_reg   <= query_y;
        e_inv_reg <= inv_next;
        e_nx_reg  <= inv_next ? NXW'(2) : nx_sat;
        e_ny_reg  <= inv_next ? NYW'(2) : ny_sat;
    end

    // segment search on each axis
    logic              lx_vld, ly_vld;
    logic [XW-1:0]     lx_seg;
    logic [YW-1:0]     ly_seg;
    frac_ctl_t         lx_ctl, ly_ctl;
    logic [DATA_W-1:0] lx_num, lx_span, ly_num, ly_span;
    logic              l_inv_reg [LOC_LAT];

    always_ff @(posedge clk)
    begin
        l_inv_reg[0] <= e_inv_reg;
        for (int k = 1; k < LOC_LAT; k++)
        begin
            l_inv_reg[k] <= l_inv_reg[k-1];
        end
    end

    bti_axis_locate #(.MAX_N(MAX_ROWS)) u_loc_x (
        .clk(clk), .rst_n(rst_n), .in_vld(e_vld_reg), .in_v(e_x_reg), .in_n(e_nx_reg),
        .pts(px_reg), .out_vld(lx_vld), .out_seg(lx_seg), .out_ctl(lx_ctl),
        .out_num(lx_num), .out_span(lx_span)
    );

    bti_axis_locate #(.MAX_N(MAX_COLS)) u_loc_y (
        .clk(clk), .rst_n(rst_n), .in_vld(e_vld_reg), .in_v(e_y_reg), .in_n(e_ny_reg),
        .pts(py_reg), .out_vld(ly_vld), .out_seg(ly_seg), .out_ctl(ly_ctl),
        .out_num(ly_num), .out_span(ly_span)
    );

    // fractions
    logic            dx_vld, dy_vld;
    logic [FRAC_W:0] dx_frac, dy_frac;
    logic [XW:0]     dx_tag;
    logic [YW-1:0]   dy_seg;

    bti_frac_div #(.TAG_W(XW + 1)) u_div_x (
        .clk(clk), .rst_n(rst_n), .in_vld(lx_vld), .in_num(lx_num), .in_span(lx_span),
        .in_ctl(lx_ctl), .in_tag({l_inv_reg[LOC_LAT-1], lx_seg}),
        .out_vld(dx_vld), .out_frac(dx_frac), .out_tag(dx_tag)
    );

    bti_frac_div #(.TAG_W(YW)) u_div_y (
        .clk(clk), .rst_n(rst_n), .in_vld(ly_vld), .in_num(ly_num), .in_span(ly_span),
        .in_ctl(ly_ctl), .in_tag(ly_seg),
        .out_vld(dy_vld), .out_frac(dy_frac), .out_tag(dy_seg)
    );

    // value table: four banks split by row and column parity
    logic signed [DATA_W-1:0] mem [2][2][BANK_D];
    logic signed [DATA_W-1:0] rd_reg [2][2];
    logic [BANK_AW-1:0]       waddr;
    logic [BANK_AW-1:0]       raddr [2][2];
    logic [XW-1:0]            dx_seg;
    logic                     m_vld_reg, m_inv_reg, m_px_reg, m_py_reg;
    logic [FRAC_W:0]          m_fx_reg, m_fy_reg;

    assign dx_seg = dx_tag[XW-1:0];
    assign waddr  = BANK_AW'((32'(row) >> 1) * HC + (32'(col) >> 1));

    always_comb
    begin
        for (int pr = 0; pr < 2; pr++)
        begin
            for (int pc = 0; pc < 2; pc++)
            begin
                raddr[pr][pc] = BANK_AW'(
                    ((32'(dx_seg) + 32'(dx_seg[0] ^ pr[0])) >> 1) * HC +
                    ((32'(dy_seg) + 32'(dy_seg[0] ^ pc[0])) >> 1));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && act == ACT_WR_VAL && 32'(row) < MAX_ROWS && 32'(col) < MAX_COLS)
            mem[row[0]][col[0]][waddr] <= data;
    end

    always_ff @(posedge clk)
    begin
        for (int pr = 0; pr < 2; pr++)
        begin
            for (int pc = 0; pc < 2; pc++)
            begin
                rd_reg[pr][pc] <= mem[pr][pc][raddr[pr][pc]];
            end
        end
        m_inv_reg <= dx_tag[XW];
        m_px_reg  <= dx_seg[0];
        m_py_reg  <= dy_seg[0];
        m_fx_reg  <= dx_frac;
        m_fy_reg  <= dy_frac;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_vld_reg <= 1'b0;
        else
            m_vld_reg <= dx_vld;
    end

    // blend along the first axis, then the second
    logic                     bx0_vld, bx1_vld, by_vld;
    logic signed [DATA_W-1:0] bx0_res, bx1_res, by_res;
    logic [FRAC_W+1:0]        bx0_tag;
    logic                     bx1_tag, by_inv;

    bti_blend #(.TAG_W(FRAC_W + 2)) u_blend_x0 (
        .clk(clk), .rst_n(rst_n), .in_vld(m_vld_reg),
        .in_a(rd_reg[m_px_reg][m_py_reg]), .in_b(rd_reg[!m_px_reg][m_py_reg]),
        .in_frac(m_fx_reg), .in_tag({m_inv_reg, m_fy_reg}),
        .out_vld(bx0_vld), .out_res(bx0_res), .out_tag(bx0_tag)
    );

    bti_blend #(.TAG_W(1)) u_blend_x1 (
        .clk(clk), .rst_n(rst_n), .in_vld(m_vld_reg),
        .in_a(rd_reg[m_px_reg][!m_py_reg]), .in_b(rd_reg[!m_px_reg][!m_py_reg]),
        .in_frac(m_fx_reg), .in_tag(m_inv_reg),
        .out_vld(bx1_vld), .out_res(bx1_res), .out_tag(bx1_tag)
    );

    bti_blend #(.TAG_W(1)) u_blend_y (
        .clk(clk), .rst_n(rst_n), .in_vld(bx0_vld), .in_a(bx0_res), .in_b(bx1_res),
        .in_frac(bx0_tag[FRAC_W:0]), .in_tag(bx0_tag[FRAC_W+1]),
        .out_vld(by_vld), .out_res(by_res), .out_tag(by_inv)
    );

    // result register: zero the value of a small table
    logic signed [DATA_W-1:0] result_reg;
    logic                     status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= by_vld;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= by_inv ? '0 : by_res;
        status_reg <= by_inv;
    end

    assign done   = done_reg;
    assign result = result_reg;
    assign status = status_reg;

    `BTI_ASSERT(a_done_counted, done_reg |-> (inflight_reg != '0), "done without a query in flight")
    `BTI_ASSERT(a_axis_align, dy_vld == dx_vld, "axis dividers out of step")
    `BTI_NEVER(a_blend_align, bx1_vld != bx0_vld || (bx0_vld && bx1_tag != bx0_tag[FRAC_W+1]), "first-axis blends out of step")

endmodule

### rtl/bti_axis_locate.sv
// Axis segment search: compare, binary search, segment offset and width.
// Depends on bti_pkg.
`timescale 1ns / 1ps
module bti_axis_locate
    import bti_pkg::*;
#(
    parameter int MAX_N = MAX_ROWS_DEF,
    localparam int IXW = $clog2(MAX_N),
    localparam int NW  = $clog2(MAX_N + 1)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_vld,
    input  logic signed [DATA_W-1:0] in_v,
    input  logic [NW-1:0]            in_n,
    input  logic signed [DATA_W-1:0] pts [MAX_N],
    output logic                     out_vld,
    output logic [IXW-1:0]           out_seg,
    output frac_ctl_t                out_ctl,
    output logic [DATA_W-1:0]        out_num,
    output logic [DATA_W-1:0]        out_span
);

    localparam int STEPS = (IXW > 0) ? IXW : 1;

    logic                     s1_vld_reg, s2_vld_reg, s3_vld_reg;
    logic signed [DATA_W-1:0] s1_v_reg, s2_v_reg;
    logic [NW-1:0]            s1_n_reg;
    logic [MAX_N-1:0]         s1_lt_reg, s1_lt_next;
    frac_ctl_t                s1_ctl_reg, s1_ctl_next, s2_ctl_reg, s3_ctl_reg;
    logic [IXW-1:0]           s2_seg_reg, s2_seg_next, s3_seg_reg;
    logic signed [DATA_W-1:0] s2_alo_reg, s2_alo_next, s2_ahi_reg, s2_ahi_next;
    logic [DATA_W-1:0]        s3_num_reg, s3_span_reg;

    // compare the query against every breakpoint
    always_comb
    begin
        for (int i = 0; i < MAX_N; i++)
        begin
            s1_lt_next[i] = in_v < pts[i];
        end
        s1_ctl_next.clamp_lo = in_v <= pts[0];
        s1_ctl_next.clamp_hi = in_v >= pts[IXW'(in_n - NW'(1))];
    end

    // binary search over the compare bits, then pick the segment ends
    always_comb
    begin
        logic [IXW-1:0] lo;
        logic [IXW-1:0] hi;
        logic [IXW-1:0] mid;
        lo = '0;
        hi = IXW'(s1_n_reg - NW'(1));
        mid = '0;
        for (int s = 0; s < STEPS; s++)
        begin
            if ((hi - lo) > IXW'(1))
            begin
                mid = lo + ((hi - lo) >> 1);
                if (s1_lt_reg[mid])
                    hi = mid;
                else
                    lo = mid;
            end
        end
        s2_alo_next = pts[lo];
        s2_ahi_next = pts[hi];
        if (s1_ctl_reg.clamp_lo)
            s2_seg_next = '0;
        else if (s1_ctl_reg.clamp_hi)
            s2_seg_next = IXW'(s1_n_reg - NW'(2));
        else
            s2_seg_next = lo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= in_vld;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_v_reg    <= in_v;
        s1_n_reg    <= in_n;
        s1_lt_reg   <= s1_lt_next;
        s1_ctl_reg  <= s1_ctl_next;
        s2_v_reg    <= s1_v_reg;
        s2_ctl_reg  <= s1_ctl_reg;
        s2_seg_reg  <= s2_seg_next;
        s2_alo_reg  <= s2_alo_next;
        s2_ahi_reg  <= s2_ahi_next;
        s3_ctl_reg  <= s2_ctl_reg;
        s3_seg_reg  <= s2_seg_reg;
        s3_num_reg  <= DATA_W'(s2_v_reg - s2_alo_reg);
        s3_span_reg <= DATA_W'(s2_ahi_reg - s2_alo_reg);
    end

    assign out_vld  = s3_vld_reg;
    assign out_seg  = s3_seg_reg;
    assign out_ctl  = s3_ctl_reg;
    assign out_num  = s3_num_reg;
    assign out_span = s3_span_reg;

endmodule

### rtl/bti_frac_div.sv
// Pipelined restoring divider, one quotient bit per stage, giving the fraction.
// Depends on bti_pkg.
`timescale 1ns / 1ps
module bti_frac_div
    import bti_pkg::*;
#(
    parameter int TAG_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_vld,
    input  logic [DATA_W-1:0] in_num,
    input  logic [DATA_W-1:0] in_span,
    input  frac_ctl_t         in_ctl,
    input  logic [TAG_W-1:0]  in_tag,
    output logic              out_vld,
    output logic [FRAC_W:0]   out_frac,
    output logic [TAG_W-1:0]  out_tag
);

    logic              vld_reg  [DIV_STEPS+1];
    logic [DATA_W-1:0] rem_reg  [DIV_STEPS+1];
    logic [DATA_W-1:0] span_reg [DIV_STEPS+1];
    logic [FRAC_W-1:0] quo_reg  [DIV_STEPS+1];
    frac_ctl_t         ctl_reg  [DIV_STEPS+1];
    logic [TAG_W-1:0]  tag_reg  [DIV_STEPS+1];
    logic [DATA_W-1:0] rem_next [DIV_STEPS];
    logic [FRAC_W-1:0] quo_next [DIV_STEPS];
    logic [FRAC_W:0]   frac_next;
    logic              out_vld_reg;
    logic [FRAC_W:0]   out_frac_reg;
    logic [TAG_W-1:0]  out_tag_reg;

    // one shift-and-subtract per stage
    always_comb
    begin
        logic [DATA_W:0] r2;
        logic            ge;
        r2 = '0;
        ge = 1'b0;
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            r2 = {rem_reg[k], 1'b0};
            ge = r2 >= {1'b0, span_reg[k]};
            rem_next[k] = ge ? DATA_W'(r2 - {1'b0, span_reg[k]}) : DATA_W'(r2);
            quo_next[k] = {quo_reg[k][FRAC_W-2:0], ge};
        end
    end

    // clamp below the first point to zero and above the last to one
    always_comb
    begin
        if (ctl_reg[DIV_STEPS].clamp_lo)
            frac_next = '0;
        else if (ctl_reg[DIV_STEPS].clamp_hi)
            frac_next = FRAC_ONE;
        else
            frac_next = {1'b0, quo_reg[DIV_STEPS]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= DIV_STEPS; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
            out_vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_vld;
            for (int k = 0; k < DIV_STEPS; k++)
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
            out_vld_reg <= vld_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= in_num;
        span_reg[0] <= in_span;
        quo_reg[0]  <= '0;
        ctl_reg[0]  <= in_ctl;
        tag_reg[0]  <= in_tag;
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            rem_reg[k+1]  <= rem_next[k];
            span_reg[k+1] <= span_reg[k];
            quo_reg[k+1]  <= quo_next[k];
            ctl_reg[k+1]  <= ctl_reg[k];
            tag_reg[k+1]  <= tag_reg[k];
        end
        out_frac_reg <= frac_next;
        out_tag_reg  <= tag_reg[DIV_STEPS];
    end

    assign out_vld  = out_vld_reg;
    assign out_frac = out_frac_reg;
    assign out_tag  = out_tag_reg;

endmodule

### rtl/bti_blend.sv
// Three-stage linear blend a + floor((b - a) * f / 65536).
// Depends on bti_pkg.
`timescale 1ns / 1ps
module bti_blend
    import bti_pkg::*;
#(
    parameter int TAG_W = 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_vld,
    input  logic signed [DATA_W-1:0] in_a,
    input  logic signed [DATA_W-1:0] in_b,
    input  logic [FRAC_W:0]          in_frac,
    input  logic [TAG_W-1:0]         in_tag,
    output logic                     out_vld,
    output logic signed [DATA_W-1:0] out_res,
    output logic [TAG_W-1:0]         out_tag
);

    localparam int PW = DATA_W + FRAC_W + 3;

    logic                     s1_vld_reg, s2_vld_reg, s3_vld_reg;
    logic signed [DATA_W-1:0] s1_a_reg, s2_a_reg, s3_res_reg;
    logic signed [DATA_W:0]   s1_diff_reg;
    logic [FRAC_W:0]          s1_frac_reg;
    logic signed [PW-1:0]     s2_prod_reg;
    logic [TAG_W-1:0]         s1_tag_reg, s2_tag_reg, s3_tag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= in_vld;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
        end
    end

    // difference, product, then add back the floored quotient
    always_ff @(posedge clk)
    begin
        s1_a_reg    <= in_a;
        s1_diff_reg <= (DATA_W+1)'(in_b) - (DATA_W+1)'(in_a);
        s1_frac_reg <= in_frac;
        s1_tag_reg  <= in_tag;
        s2_a_reg    <= s1_a_reg;
        s2_prod_reg <= s1_diff_reg * $signed({1'b0, s1_frac_reg});
        s2_tag_reg  <= s1_tag_reg;
        s3_res_reg  <= s2_a_reg + s2_prod_reg[DATA_W+FRAC_W-1:FRAC_W];
        s3_tag_reg  <= s2_tag_reg;
    end

    assign out_vld = s3_vld_reg;
    assign out_res = s3_res_reg;
    assign out_tag = s3_tag_reg;

endmodule
